// ===== design/fmbs_pkg.sv =====
`timescale 1ns / 1ps
// fmbs_pkg: shared types, codes and helpers for the FM-index backward search core.
// No dependencies; used by every module in the design folder.
package fmbs_pkg;

  localparam int SYM_W          = 8;
  localparam int POS_W          = 12;
  localparam int BOUND_W        = 13;
  localparam int STAT_W         = 2;
  localparam int REQ_W          = 2;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int DEF_TEXT_DEPTH = 4096;
  localparam int DEF_ALPHABET   = 256;

  localparam logic [BOUND_W-1:0] BOUND_MAX = 13'h1FFF;

  localparam logic [REQ_W-1:0] REQ_LOAD_TEXT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_TABLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PATTERN    = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FOUND     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_AT_START  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_TEXT_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_NEXT,
    ST_RANK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [SYM_W-1:0]   sym;
    logic [BOUND_W-1:0] n_first;
    logic [BOUND_W-1:0] n_last;
  } rank_cmd_t;

  // counts are clipped to the bound range; anything above saturates later anyway
  typedef struct packed {
    logic               done;
    logic [BOUND_W-1:0] c_first;
    logic [BOUND_W-1:0] c_last;
  } rank_stat_t;

  function automatic logic [BOUND_W-1:0] sat_bound(input logic [BOUND_W:0] v);
    return v[BOUND_W] ? BOUND_MAX : v[BOUND_W-1:0];
  endfunction

endpackage

// ===== design/fmbs_table.sv =====
`timescale 1ns / 1ps
// fmbs_table: start-offset table, one entry per symbol, with per-entry valid bits.
// An entry never written since reset reads as zero. Depends on fmbs_pkg.
module fmbs_table #(
  parameter int ALPHABET = fmbs_pkg::DEF_ALPHABET,
  localparam int AW = $clog2(ALPHABET)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [fmbs_pkg::BOUND_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [fmbs_pkg::BOUND_W-1:0] rd_data
);

  logic [fmbs_pkg::BOUND_W-1:0] mem [ALPHABET];
  logic [ALPHABET-1:0]          valid;
  logic [fmbs_pkg::BOUND_W-1:0] rd_q;
  logic                         rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== design/fmbs_text.sv =====
`timescale 1ns / 1ps
// fmbs_text: BWT text store, one symbol per position, registered read port.
// Contents are undefined until written. Depends on fmbs_pkg.
module fmbs_text #(
  parameter int TEXT_DEPTH = fmbs_pkg::DEF_TEXT_DEPTH,
  localparam int AW = $clog2(TEXT_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [fmbs_pkg::SYM_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [fmbs_pkg::SYM_W-1:0] rd_data
);

  logic [fmbs_pkg::SYM_W-1:0] mem [TEXT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/fmbs_rank.sv =====
`timescale 1ns / 1ps
// fmbs_rank: rank unit; walks the text store one position a cycle and counts a
// symbol below two prefix lengths at once. Depends on fmbs_pkg, drives fmbs_text reads.
module fmbs_rank #(
  parameter int TEXT_DEPTH = fmbs_pkg::DEF_TEXT_DEPTH,
  localparam int AW = $clog2(TEXT_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fmbs_pkg::rank_cmd_t        cmd,
  output logic [AW-1:0]              rd_addr,
  input  logic [fmbs_pkg::SYM_W-1:0] rd_data,
  output fmbs_pkg::rank_stat_t       stat
);

  localparam int PW = AW + 1;
  localparam int CW = (PW > fmbs_pkg::BOUND_W) ? PW : fmbs_pkg::BOUND_W;

  logic                         busy;
  logic [PW-1:0]                pos;
  logic [AW-1:0]                pos_d;
  logic                         live;
  logic [fmbs_pkg::SYM_W-1:0]   sym_q;
  logic [fmbs_pkg::BOUND_W-1:0] nf_q;
  logic [fmbs_pkg::BOUND_W-1:0] nl_q;
  logic [PW-1:0]                limit_q;
  logic [PW-1:0]                cf;
  logic [PW-1:0]                cl;

  logic [fmbs_pkg::BOUND_W-1:0] n_max;
  logic [PW-1:0]                limit;
  logic                         issue;
  logic                         hit;

  assign n_max = (cmd.n_first > cmd.n_last) ? cmd.n_first : cmd.n_last;
  // scan length saturates at the store depth
  assign limit = (CW'(n_max) > CW'(TEXT_DEPTH)) ? PW'(TEXT_DEPTH) : PW'(n_max);
  assign issue = busy && (pos < limit_q);
  assign hit   = live && (rd_data == sym_q);
  assign rd_addr = pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      live <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      live <= 1'b0;
    end else begin
      live <= issue;
      if (busy && !issue && !live) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sym_q   <= cmd.sym;
      nf_q    <= cmd.n_first;
      nl_q    <= cmd.n_last;
      limit_q <= limit;
      pos     <= '0;
      cf      <= '0;
      cl      <= '0;
    end else begin
      if (issue) begin
        pos <= pos + PW'(1);
      end
      pos_d <= pos[AW-1:0];
      if (hit && (CW'(pos_d) < CW'(nf_q))) begin
        cf <= cf + PW'(1);
      end
      if (hit && (CW'(pos_d) < CW'(nl_q))) begin
        cl <= cl + PW'(1);
      end
    end
  end

  assign stat.done    = busy && !issue && !live;
  assign stat.c_first = (CW'(cf) > CW'(fmbs_pkg::BOUND_MAX)) ? fmbs_pkg::BOUND_MAX
                                                             : fmbs_pkg::BOUND_W'(cf);
  assign stat.c_last  = (CW'(cl) > CW'(fmbs_pkg::BOUND_MAX)) ? fmbs_pkg::BOUND_MAX
                                                             : fmbs_pkg::BOUND_W'(cl);

`ifndef SYNTHESIS
  a_done_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !busy || $past(cmd.start))
    else $error("rank unit still busy after done");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy)
    else $error("rank unit restarted while busy");
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    busy && (nf_q <= nl_q) |-> cf <= cl)
    else $error("rank counts out of order");
`endif

endmodule

// ===== design/fm_index_backward_search_core.sv =====
`timescale 1ns / 1ps
// fm_index_backward_search_core: top level; sequencer, config register, output word.
// Depends on fmbs_pkg, fmbs_table, fmbs_text, fmbs_rank.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  input   | in_valid / in_stall    | req_type symbol load_position table_value
//          |                        | pattern_start pattern_end
//  output  | out_valid / out_stall  | status range_first range_last
//  config  | psel penable pwrite    | paddr pwdata prdata (text_length at 0x0)
//
// Loads do not stall the input. A search start symbol walks the start-offset table read port
// upward from the next symbol, one entry a cycle, until a nonzero entry or the alphabet end.
// A later symbol runs the rank unit, which reads the text store one position a cycle over
// min(max(first-1, last), TEXT_DEPTH) positions.
// Reset is synchronous; the table valid bits clear at once, so no clearing pass is run.
// A held output word stalls only the end-of-pattern step; in_stall is high while busy.
module fm_index_backward_search_core #(
  parameter int TEXT_DEPTH = fmbs_pkg::DEF_TEXT_DEPTH,
  parameter int ALPHABET   = fmbs_pkg::DEF_ALPHABET
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fmbs_pkg::REQ_W-1:0]    req_type,
  input  logic [fmbs_pkg::SYM_W-1:0]    symbol,
  input  logic [fmbs_pkg::POS_W-1:0]    load_position,
  input  logic [fmbs_pkg::BOUND_W-1:0]  table_value,
  input  logic                          pattern_start,
  input  logic                          pattern_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fmbs_pkg::STAT_W-1:0]   status,
  output logic [fmbs_pkg::BOUND_W-1:0]  range_first,
  output logic [fmbs_pkg::BOUND_W-1:0]  range_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmbs_pkg::PADDR_W-1:0]  paddr,
  input  logic [fmbs_pkg::PDATA_W-1:0]  pwdata,
  output logic [fmbs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int SAW = $clog2(ALPHABET);
  localparam int LW  = (TAW + 1 > fmbs_pkg::POS_W + 1) ? TAW + 1 : fmbs_pkg::POS_W + 1;
  localparam int IW  = fmbs_pkg::SYM_W + 1;
  localparam int BW  = fmbs_pkg::BOUND_W;

  fmbs_pkg::state_t state, state_next;

  logic [fmbs_pkg::SYM_W-1:0]  sym_q;
  logic                        pstart_q;
  logic                        pend_q;
  logic                        symok_q;
  logic [BW-1:0]               base_q, base_next;
  logic [IW-1:0]               scan_idx, scan_idx_next;
  logic                        rd_live, rd_live_next;
  logic [BW-1:0]               cur_first, cur_first_next;
  logic [BW-1:0]               cur_last, cur_last_next;
  logic                        search_done, search_done_next;
  logic [fmbs_pkg::STAT_W-1:0] held_status, held_status_next;
  logic [BW-1:0]               text_length;
  logic                        out_load;

  logic                        accept;
  logic                        pos_ok;
  logic                        sym_ok;
  logic                        txt_we;
  logic                        tbl_we;
  logic [SAW-1:0]              tbl_raddr;
  logic [BW-1:0]               tbl_rd;
  logic [TAW-1:0]              txt_raddr;
  logic [fmbs_pkg::SYM_W-1:0]  txt_rd;
  fmbs_pkg::rank_cmd_t         rk_cmd;
  fmbs_pkg::rank_stat_t        rk_st;

  logic                        scan_more;
  logic                        scan_hit;
  logic [BW-1:0]               start_first;
  logic [BW-1:0]               start_last;
  logic [BW-1:0]               rank_first;
  logic [BW-1:0]               rank_last;

  assign in_stall = (state != fmbs_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign pos_ok   = LW'(load_position) < LW'(TEXT_DEPTH);
  assign sym_ok   = IW'(symbol) < IW'(ALPHABET);
  assign txt_we   = accept && (req_type == fmbs_pkg::REQ_LOAD_TEXT) && pos_ok;
  assign tbl_we   = accept && (req_type == fmbs_pkg::REQ_LOAD_TABLE) && sym_ok;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fmbs_pkg::REG_TEXT_LENGTH)
                ? fmbs_pkg::PDATA_W'(text_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= '0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == fmbs_pkg::REG_TEXT_LENGTH)) begin
      text_length <= pwdata[BW-1:0];
    end
  end

  fmbs_table #(.ALPHABET(ALPHABET)) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_we),
    .wr_addr (symbol[SAW-1:0]),
    .wr_data (table_value),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rd)
  );

  fmbs_text #(.TEXT_DEPTH(TEXT_DEPTH)) u_text (
    .clk     (clk),
    .wr_en   (txt_we),
    .wr_addr (TAW'(load_position)),
    .wr_data (symbol),
    .rd_addr (txt_raddr),
    .rd_data (txt_rd)
  );

  fmbs_rank #(.TEXT_DEPTH(TEXT_DEPTH)) u_rank (
    .clk     (clk),
    .rst     (rst),
    .cmd     (rk_cmd),
    .rd_addr (txt_raddr),
    .rd_data (txt_rd),
    .stat    (rk_st)
  );

  // range arithmetic
  assign scan_more   = scan_idx < IW'(ALPHABET);
  assign scan_hit    = rd_live && (tbl_rd != '0);
  assign start_first = fmbs_pkg::sat_bound({1'b0, base_q} + (BW+1)'(1));
  assign start_last  = scan_hit ? tbl_rd : text_length;
  assign rank_first  = fmbs_pkg::sat_bound({1'b0, base_q} + {1'b0, rk_st.c_first}
                                           + (BW+1)'(1));
  assign rank_last   = fmbs_pkg::sat_bound({1'b0, base_q} + {1'b0, rk_st.c_last});

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fmbs_pkg::ST_IDLE;
      rd_live     <= 1'b0;
      cur_first   <= '0;
      cur_last    <= '0;
      search_done <= 1'b0;
      held_status <= fmbs_pkg::STATUS_NOT_FOUND;
    end else begin
      state       <= state_next;
      rd_live     <= rd_live_next;
      cur_first   <= cur_first_next;
      cur_last    <= cur_last_next;
      search_done <= search_done_next;
      held_status <= held_status_next;
    end
  end

  always_ff @(posedge clk) begin
    base_q   <= base_next;
    scan_idx <= scan_idx_next;
    if (accept && (req_type == fmbs_pkg::REQ_PATTERN)) begin
      sym_q    <= symbol;
      pstart_q <= pattern_start;
      pend_q   <= pattern_end;
      symok_q  <= sym_ok;
    end
  end

  always_comb begin
    state_next       = state;
    base_next        = base_q;
    scan_idx_next    = scan_idx;
    rd_live_next     = rd_live;
    cur_first_next   = cur_first;
    cur_last_next    = cur_last;
    search_done_next = search_done;
    held_status_next = held_status;
    tbl_raddr        = scan_idx[SAW-1:0];
    rk_cmd           = '0;
    out_load         = 1'b0;
    case (state)
      fmbs_pkg::ST_IDLE: begin
        tbl_raddr = symbol[SAW-1:0];
        if (accept && (req_type == fmbs_pkg::REQ_PATTERN)) begin
          state_next = fmbs_pkg::ST_BASE;
        end
      end
      fmbs_pkg::ST_BASE: begin
        base_next = symok_q ? tbl_rd : '0;
        if (pstart_q) begin
          scan_idx_next = IW'(sym_q) + IW'(1);
          rd_live_next  = 1'b0;
          state_next    = fmbs_pkg::ST_NEXT;
        end else if (search_done) begin
          state_next = fmbs_pkg::ST_OUT;
        end else if (cur_first <= BW'(1)) begin
          search_done_next = 1'b1;
          held_status_next = fmbs_pkg::STATUS_AT_START;
          state_next       = fmbs_pkg::ST_OUT;
        end else begin
          rk_cmd.start   = 1'b1;
          rk_cmd.sym     = sym_q;
          rk_cmd.n_first = cur_first - BW'(1);
          rk_cmd.n_last  = cur_last;
          state_next     = fmbs_pkg::ST_RANK;
        end
      end
      fmbs_pkg::ST_NEXT: begin
        // walk upward for the next present symbol; table reads are registered
        if (scan_hit || !scan_more) begin
          cur_first_next = start_first;
          cur_last_next  = start_last;
          if ((start_first == BW'(1)) || (start_last < start_first)) begin
            search_done_next = 1'b1;
            held_status_next = fmbs_pkg::STATUS_NOT_FOUND;
          end else begin
            search_done_next = 1'b0;
            held_status_next = fmbs_pkg::STATUS_FOUND;
          end
          rd_live_next = 1'b0;
          state_next   = fmbs_pkg::ST_OUT;
        end else begin
          scan_idx_next = scan_idx + IW'(1);
          rd_live_next  = 1'b1;
        end
      end
      fmbs_pkg::ST_RANK: begin
        if (rk_st.done) begin
          cur_first_next = rank_first;
          cur_last_next  = rank_last;
          if (rank_last < rank_first) begin
            search_done_next = 1'b1;
            held_status_next = fmbs_pkg::STATUS_NOT_FOUND;
          end else begin
            held_status_next = fmbs_pkg::STATUS_FOUND;
          end
          state_next = fmbs_pkg::ST_OUT;
        end
      end
      fmbs_pkg::ST_OUT: begin
        if (!pend_q) begin
          state_next = fmbs_pkg::ST_IDLE;
        end else if (!out_valid || !out_stall) begin
          out_load         = 1'b1;
          search_done_next = 1'b1;
          state_next       = fmbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fmbs_pkg::ST_IDLE;
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= held_status;
      range_first <= cur_first;
      range_last  <= cur_last;
    end
  end

`ifndef SYNTHESIS
  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == fmbs_pkg::ST_OUT)
    else $error("output word raised outside result step");
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fmbs_pkg::STATUS_FOUND) |-> range_first <= range_last)
    else $error("found status with empty range");
  a_rank_in_step: assert property (@(posedge clk) disable iff (rst)
    rk_st.done |-> state == fmbs_pkg::ST_RANK)
    else $error("rank result outside rank step");
  a_pattern_enters: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == fmbs_pkg::REQ_PATTERN) |=> state == fmbs_pkg::ST_BASE)
    else $error("pattern word did not start the sequencer");
`endif

endmodule

// ===== tb/sv/fm_index_backward_search_core_test.sv =====
`timescale 1ns / 1ps
// fm_index_backward_search_core_test: self-checking bench for the FM-index search core.
// Needs fmbs_pkg and the core; predicts result words in-bench (directed rows give their own) and checks them in order.
module fm_index_backward_search_core_test;
  import fmbs_pkg::*;

  localparam int TEXT_DEPTH   = DEF_TEXT_DEPTH;
  localparam int ALPHABET     = DEF_ALPHABET;
  localparam int QUIET_CYCLES = TEXT_DEPTH + 300;  // longest rank scan plus margin
  // text positions written up front
  localparam int PREFIX       = 16;

  localparam logic [REQ_W-1:0]   REQ_UNKNOWN      = 2'd3;
  localparam logic [PADDR_W-1:0] TEXT_LENGTH_ADDR = {REG_TEXT_LENGTH, 2'b00};

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [SYM_W-1:0]   sym;
    logic [POS_W-1:0]   pos;
    logic [BOUND_W-1:0] val;
    logic               ps;
    logic               pe;
  } word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  st;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } range_t;

  typedef struct packed {
    word_t  w;
    logic   typed;
    range_t want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type;
  logic [SYM_W-1:0]     symbol;
  logic [POS_W-1:0]     load_position;
  logic [BOUND_W-1:0]   table_value;
  logic                 pattern_start;
  logic                 pattern_end;
  logic                 out_valid;
  logic                 out_stall;
  logic [STAT_W-1:0]    status;
  logic [BOUND_W-1:0]   range_first;
  logic [BOUND_W-1:0]   range_last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // predictor state
  logic [SYM_W-1:0]   text_mem [TEXT_DEPTH];
  logic [BOUND_W-1:0] offset_table [ALPHABET];
  int                 range_lo;
  int                 range_hi;
  bit                 stopped;
  logic [STAT_W-1:0]  held_code;
  int                 text_len;

  range_t     owed_ranges [$];
  row_t       plan [$];
  int         dirty_syms [$];
  int         mismatches;
  bit         calm;
  range_t     seen;
  range_t     owed;

  fm_index_backward_search_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .symbol(symbol), .load_position(load_position),
    .table_value(table_value), .pattern_start(pattern_start), .pattern_end(pattern_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .range_first(range_first), .range_last(range_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BOUND_W-1:0] clip(input int v);
    return (v > int'(BOUND_MAX)) ? BOUND_MAX : v[BOUND_W-1:0];
  endfunction

  function automatic int next_offset(input int s);
    int i;
    for (i = s + 1; i < ALPHABET; i++)
      if (offset_table[i] != 0) return int'(offset_table[i]);
    return text_len;
  endfunction

  // occurrences of s in stored positions 0 .. n-1
  function automatic int count_before(input logic [SYM_W-1:0] s, input int n);
    int i;
    int c;
    int lim;
    c = 0;
    lim = (n > TEXT_DEPTH) ? TEXT_DEPTH : n;
    for (i = 0; i < lim; i++)
      if (text_mem[i] == s) c++;
    return c;
  endfunction

  function automatic bit predict_search(input word_t w, output range_t r);
    int base;
    int nlo;
    int nhi;
    r = '0;
    case (w.req)
      REQ_LOAD_TEXT: begin
        text_mem[w.pos] = w.sym;
        return 1'b0;
      end
      REQ_LOAD_TABLE: begin
        offset_table[w.sym] = w.val;
        return 1'b0;
      end
      REQ_PATTERN: ;
      default: return 1'b0;
    endcase
    if (w.ps) begin
      range_lo = clip(int'(offset_table[w.sym]) + 1);
      range_hi = clip(next_offset(w.sym));
      stopped = 1'b0;
      held_code = STATUS_FOUND;
      if (range_lo == 1 || range_hi < range_lo) begin
        stopped = 1'b1;
        held_code = STATUS_NOT_FOUND;
      end
    end else if (!stopped) begin
      if (range_lo <= 1) begin
        stopped = 1'b1;
        held_code = STATUS_AT_START;
      end else begin
        base = int'(offset_table[w.sym]);
        nlo = clip(base + count_before(w.sym, range_lo - 1) + 1);
        nhi = clip(base + count_before(w.sym, range_hi));
        range_lo = nlo;
        range_hi = nhi;
        held_code = STATUS_FOUND;
        if (range_hi < range_lo) begin
          stopped = 1'b1;
          held_code = STATUS_NOT_FOUND;
        end
      end
    end
    if (!w.pe) return 1'b0;
    r.st = held_code;
    r.lo = range_lo[BOUND_W-1:0];
    r.hi = range_hi[BOUND_W-1:0];
    stopped = 1'b1;
    return 1'b1;
  endfunction

  function automatic word_t mk_word(input logic [REQ_W-1:0] req, input int sym, input int pos,
                                    input int val, input bit ps, input bit pe);
    word_t w;
    w.req = req;
    w.sym = sym[SYM_W-1:0];
    w.pos = pos[POS_W-1:0];
    w.val = val[BOUND_W-1:0];
    w.ps = ps;
    w.pe = pe;
    return w;
  endfunction

  function automatic void add_row(input logic [REQ_W-1:0] req, input int sym, input int pos,
                                  input int val, input bit ps, input bit pe, input bit typed,
                                  input logic [STAT_W-1:0] st, input int lo, input int hi);
    row_t r;
    r.w = mk_word(req, sym, pos, val, ps, pe);
    r.typed = typed;
    r.want.st = st;
    r.want.lo = lo[BOUND_W-1:0];
    r.want.hi = hi[BOUND_W-1:0];
    plan.push_back(r);
  endfunction

  // present one word, wait for it to be taken, then log what it should produce
  task automatic send_word(input word_t w, input bit typed, input range_t typed_want);
    range_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= w.req;
    symbol <= w.sym;
    load_position <= w.pos;
    table_value <= w.val;
    pattern_start <= w.ps;
    pattern_end <= w.pe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_search(w, r)) owed_ranges.push_back(typed ? typed_want : r);
  endtask

  // hold off the sender until every owed word is back and the core has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_ranges.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_length(input int v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TEXT_LENGTH_ADDR;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    text_len = v & 32'h1FFF;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input range_t want, input range_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected st=%0d first=%0d last=%0d, got st=%0d first=%0d last=%0d",
               $time, what, want.st, want.lo, want.hi, got.st, got.lo, got.hi);
  endtask

  always @(negedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 29);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.st = status;
      seen.lo = range_first;
      seen.hi = range_last;
      if (owed_ranges.size() == 0) begin
        flag_mismatch("result word with nothing owed", '0, seen);
      end else begin
        owed = owed_ranges.pop_front();
        if (seen.st !== owed.st || seen.lo !== owed.lo || seen.hi !== owed.hi)
          flag_mismatch("result word mismatch", owed, seen);
      end
    end
  end

  initial begin
    #(50_000_000);
    $display("fm_index_backward_search_core_test NOT OK");
    $finish;
  end

  initial begin
    int i;
    int j;
    int p;
    int ph;
    int len;
    int hole;
    int base;
    int k;
    int plen;
    int off;
    int pick;
    int s;
    int nreq;
    int pos;
    int val;
    int cnt [3];
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_LOAD_TEXT;
    symbol = '0;
    load_position = '0;
    table_value = '0;
    pattern_start = 1'b0;
    pattern_end = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    calm = 1'b0;
    range_lo = 0;
    range_hi = 0;
    stopped = 1'b0;
    held_code = STATUS_NOT_FOUND;
    text_len = 0;
    for (i = 0; i < ALPHABET; i++) offset_table[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_text_length(0);

    // only a short prefix is written here
    for (i = 0; i < PREFIX; i++)
      send_word(mk_word(REQ_LOAD_TEXT, 255, i, $urandom_range(0, 4096),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);

    // directed: text prefix is all 255, text length 0
    add_row(REQ_PATTERN, 0, 0, 0, 1'b0, 1'b1, 1'b1, STATUS_AT_START, 0, 0);
    add_row(REQ_UNKNOWN, 255, 4095, 4096, 1'b1, 1'b1, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_LOAD_TABLE, 255, 0, 8191, 1'b0, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_LOAD_TABLE, 7, 4095, 2, 1'b1, 1'b1, 1'b0, STATUS_NOT_FOUND, 0, 0);
    // first bound saturates on the start symbol
    add_row(REQ_PATTERN, 255, 0, 0, 1'b1, 1'b1, 1'b1, STATUS_NOT_FOUND, 8191, 0);
    add_row(REQ_PATTERN, 7, 4095, 4096, 1'b1, 1'b1, 1'b1, STATUS_FOUND, 3, 8191);
    add_row(REQ_PATTERN, 0, 0, 0, 1'b1, 1'b1, 1'b1, STATUS_NOT_FOUND, 1, 2);
    add_row(REQ_LOAD_TABLE, 9, 0, 12, 1'b0, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    // rank step bounds run past the 13-bit range and saturate
    add_row(REQ_PATTERN, 7, 0, 0, 1'b1, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 255, 0, 0, 1'b0, 1'b1, 1'b1, STATUS_FOUND, 8191, 8191);
    add_row(REQ_PATTERN, 3, 0, 0, 1'b0, 1'b1, 1'b1, STATUS_FOUND, 8191, 8191);
    // range empties mid-search, then the end mark repeats it
    add_row(REQ_PATTERN, 7, 0, 0, 1'b1, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 0, 0, 0, 1'b0, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 255, 0, 0, 1'b0, 1'b1, 1'b0, STATUS_NOT_FOUND, 0, 0);
    // first row drops to 1, next symbol hits the text start
    add_row(REQ_LOAD_TEXT, 0, 3, 0, 1'b0, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 7, 0, 0, 1'b1, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 0, 0, 0, 1'b0, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 9, 0, 0, 1'b0, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 255, 0, 0, 1'b0, 1'b1, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_LOAD_TEXT, 0, 4095, 4096, 1'b1, 1'b0, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_LOAD_TABLE, 128, 2048, 0, 1'b0, 1'b1, 1'b0, STATUS_NOT_FOUND, 0, 0);
    add_row(REQ_PATTERN, 128, 0, 0, 1'b1, 1'b1, 1'b0, STATUS_NOT_FOUND, 0, 0);
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].want);

    // full text length; upper bound now comes from the register
    settle();
    write_text_length(4096);
    send_word(mk_word(REQ_PATTERN, 255, 0, 0, 1'b1, 1'b1), 1'b0, '0);
    send_word(mk_word(REQ_LOAD_TABLE, 255, 0, 0, 1'b0, 1'b0), 1'b0, '0);
    send_word(mk_word(REQ_PATTERN, 7, 0, 0, 1'b1, 1'b1), 1'b0, '0);
    send_word(mk_word(REQ_PATTERN, 7, 0, 0, 1'b1, 1'b0), 1'b0, '0);
    send_word(mk_word(REQ_PATTERN, 255, 0, 0, 1'b0, 1'b1), 1'b0, '0);
    dirty_syms.push_back(7);
    dirty_syms.push_back(9);

    // random: small consistent indexes over three symbols plus a 0 sentinel
    for (ph = 0; ph < 2; ph++) begin
      settle();
      calm = (ph == 1);
      len = $urandom_range(6, 14);
      write_text_length(len);
      while (dirty_syms.size() != 0)
        send_word(mk_word(REQ_LOAD_TABLE, dirty_syms.pop_front(), $urandom_range(0, 4095), 0,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);
      base = $urandom_range(128, 247);
      hole = $urandom_range(0, len - 1);
      for (k = 0; k < 3; k++) cnt[k] = 0;
      for (i = 0; i < len; i++) begin
        if (i == hole) begin
          s = 0;
        end else begin
          k = $urandom_range(0, 2);
          cnt[k]++;
          s = base + 2 * k;
        end
        send_word(mk_word(REQ_LOAD_TEXT, s, i, $urandom_range(0, 4096),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);
      end
      off = 1;
      for (k = 0; k < 3; k++) begin
        send_word(mk_word(REQ_LOAD_TABLE, base + 2 * k, $urandom_range(0, 4095), off,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))), 1'b0, '0);
        dirty_syms.push_back(base + 2 * k);
        off += cnt[k];
      end
      for (p = 0; p < 7; p++) begin
        if ($urandom_range(0, 99) < 20) begin
          // stray word: any request; text writes land past the live prefix,
          // table writes stay below the live symbols with offsets inside the text
          nreq = $urandom_range(0, 3);
          s = $urandom_range(0, 255);
          pos = $urandom_range(0, 4095);
          val = $urandom_range(0, 4096);
          if (nreq == int'(REQ_LOAD_TEXT)) begin
            pos = $urandom_range(PREFIX, 4095);
          end else if (nreq == int'(REQ_LOAD_TABLE)) begin
            s = $urandom_range(1, base - 1);
            val = $urandom_range(0, len);
            dirty_syms.push_back(s);
          end
          send_word(mk_word(nreq[REQ_W-1:0], s, pos, val, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))), 1'b0, '0);
        end
        plen = $urandom_range(1, 4);
        for (j = 0; j < plen; j++) begin
          pick = $urandom_range(0, 99);
          if (pick < 85) s = base + 2 * $urandom_range(0, 2);
          else if (pick < 95) s = 0;
          else s = $urandom_range(0, 255);
          send_word(mk_word(REQ_PATTERN, s, $urandom_range(0, 4095), $urandom_range(0, 4096),
                            j == 0, j == plen - 1), 1'b0, '0);
        end
      end
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0)
      $display("fm_index_backward_search_core_test OK");
    else
      $display("fm_index_backward_search_core_test NOT OK");
    $finish;
  end

endmodule
